// ----- hw/rtl/crle_pkg.sv -----
// Shared types and constants for the Catmull-Rom lattice evaluator.
// No dependencies; imported by every RTL module of the block.
package crle_pkg;

    localparam int CW       = 32;       // control point coordinate width
    localparam int WW       = 48;       // wide intermediate width
    localparam int AW       = 8;        // grid address width
    localparam int GRID_DEPTH = 256;
    localparam int TW       = 17;       // Q1.16 parameter width
    localparam int DW       = 4;        // division register width
    localparam int MW       = 3 * CW;   // one grid entry holds x, y and z

    localparam logic [TW-1:0] ONE_Q16 = 17'd65536;

    // Configuration register indexes.
    localparam logic [1:0] REG_DIV_ACROSS = 2'd0;
    localparam logic [1:0] REG_DIV_DOWN   = 2'd1;

    // Input actions.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    typedef struct packed {
        logic start;
        logic linear;
        logic refl0;
        logic refl3;
    } lane_ctl_t;

endpackage

// ----- hw/rtl/crle_grid_mem.sv -----
// Control point store: one write port, one read port, registered read data.
// Depends on crle_pkg.
module crle_grid_mem
    import crle_pkg::*;
(
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [MW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [MW-1:0] rd_data
);

    logic [MW-1:0] mem [GRID_DEPTH];
    logic [MW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/crle_cubic_lane.sv -----
// One coordinate lane: Catmull-Rom or linear interpolation by Horner steps,
// one multiply by t per cycle. Depends on crle_pkg.
module crle_cubic_lane
    import crle_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lane_ctl_t            ctl,
    input  logic        [TW-1:0] t,
    input  logic signed [WW-1:0] p0,
    input  logic signed [WW-1:0] p1,
    input  logic signed [WW-1:0] p2,
    input  logic signed [WW-1:0] p3,
    output logic signed [WW-1:0] result,
    output logic                 done
);

    logic        [1:0]    cnt_reg, cnt_next;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic                 halve_reg, halve_next;
    logic signed [WW-1:0] h_reg, h_next;
    logic signed [WW-1:0] ca_reg, ca_next;
    logic signed [WW-1:0] cb_reg, cb_next;
    logic signed [WW-1:0] cc_reg, cc_next;
    logic signed [WW-1:0] p0e, p3e, coef, mulq, hp1;
    logic signed [WW+TW:0] prod;

    always_comb begin
        p0e = ctl.refl0 ? (p1 <<< 1) - p2 : p0;
        p3e = ctl.refl3 ? (p2 <<< 1) - p1 : p3;
        case (cnt_reg)
            2'd3:    coef = cc_reg;
            2'd2:    coef = cb_reg;
            default: coef = ca_reg;
        endcase
        // h * t / 65536 rounded to nearest, ties upward.
        prod = h_reg * $signed({1'b0, t}) + $signed((WW+TW+1)'(32768));
        mulq = WW'(prod >>> 16);
        hp1  = h_reg + WW'(1);
        result = halve_reg ? (hp1 >>> 1) : h_reg;

        cnt_next   = cnt_reg;
        run_next   = run_reg;
        done_next  = 1'b0;
        halve_next = halve_reg;
        h_next     = h_reg;
        ca_next    = ca_reg;
        cb_next    = cb_reg;
        cc_next    = cc_reg;
        if (ctl.start) begin
            run_next = 1'b1;
            if (ctl.linear) begin
                h_next     = p2 - p1;
                ca_next    = p1;
                cnt_next   = 2'd1;
                halve_next = 1'b0;
            end else begin
                h_next     = (p1 <<< 1) + p1 - (p2 <<< 1) - p2 + p3e - p0e;
                cc_next    = (p0e <<< 1) - (p1 <<< 2) - p1 + (p2 <<< 2) - p3e;
                cb_next    = p2 - p0e;
                ca_next    = p1 <<< 1;
                cnt_next   = 2'd3;
                halve_next = 1'b1;
            end
        end else if (run_reg) begin
            h_next   = coef + mulq;
            cnt_next = cnt_reg - 2'd1;
            if (cnt_reg == 2'd1) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= 2'd0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
        halve_reg <= halve_next;
        h_reg     <= h_next;
        ca_reg    <= ca_next;
        cb_reg    <= cb_next;
        cc_reg    <= cc_next;
    end

    assign done = done_reg;

endmodule

// ----- hw/rtl/catmull_rom_lattice_evaluator_unit.sv -----
// Top level of the Catmull-Rom lattice evaluator: sequencer, grid store and
// three coordinate lanes. Depends on crle_pkg, crle_grid_mem, crle_cubic_lane.
//
// Usage. The input channel (s_*) carries one item per handshake. A load item
// (s_action = 0) writes one control point into grid slot s_point_index and
// produces no result. An evaluate item (s_action = 1) produces one result
// item on the m_* channel: the surface point at (s_param_u, s_param_v). The
// configuration port sets the division counts along u and v and must be
// written only while the block is idle.
//
// Sequencing. An evaluate visits up to four grid rows. Each row passes through
// these steps: one to select it, four reads from the grid store (one read per
// cycle), a wait for the registered read data, one to start the lanes, then
// three Horner steps and the hand-off. A linear axis along u needs a single
// Horner step per row. The pass along v then follows, and the result goes to
// the output register, where m_valid rises. The next item is accepted only
// after that, once the block is idle again. With one division along v only
// two rows are read. The grid store's read port and the Horner chain pace
// each evaluate.
//
// Reset clears the sequencer, the output valid and sets both division
// counts to one; grid contents are undefined until loaded. When the receiver
// stalls, a finished result waits in the output register while load items
// continue to be accepted; a further evaluate holds in its last step until
// the output register is free.
module catmull_rom_lattice_evaluator_unit
    import crle_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_index,
    input  logic [DW-1:0]        cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_action,
    input  logic [AW-1:0]        s_point_index,
    input  logic signed [CW-1:0] s_point_x,
    input  logic signed [CW-1:0] s_point_y,
    input  logic signed [CW-1:0] s_point_z,
    input  logic [TW-1:0]        s_param_u,
    input  logic [TW-1:0]        s_param_v,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [CW-1:0] m_surface_x,
    output logic signed [CW-1:0] m_surface_y,
    output logic signed [CW-1:0] m_surface_z
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ROW    = 3'd1;
    localparam logic [2:0] S_RD     = 3'd2;
    localparam logic [2:0] S_WAIT   = 3'd3;
    localparam logic [2:0] S_USTART = 3'd4;
    localparam logic [2:0] S_URUN   = 3'd5;
    localparam logic [2:0] S_VRUN   = 3'd6;
    localparam logic [2:0] S_FIN    = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic          vstart_reg, vstart_next;
    logic [DW-1:0] du_reg, dv_reg;
    logic [DW-1:0] u_seg_reg, u_seg_next, v_seg_reg, v_seg_next;
    logic [TW-1:0] u_t_reg, u_t_next, v_t_reg, v_t_next;
    logic [1:0]    rk_reg, rk_next, k_reg, k_next;
    logic          rd_v_reg, rd_v_next;
    logic [1:0]    rd_k_reg;
    logic signed [CW-1:0] pt_reg [4][3];
    logic signed [WW-1:0] row_reg [4][3];
    logic signed [CW-1:0] res_reg [3];
    logic signed [CW-1:0] mx_reg, my_reg, mz_reg;
    logic          m_valid_reg, m_valid_next;

    logic [DW-1:0] du_e, dv_e;
    logic          lin_u, lin_v;
    logic [DW-1:0] pu_seg, pv_seg;
    logic [TW-1:0] pu_t, pv_t;
    logic [4:0]    row_num;
    logic [9:0]    addr_w;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [MW-1:0] mem_rdata;
    logic          accept;

    lane_ctl_t            lane_ctl;
    logic        [TW-1:0] lane_t;
    logic signed [WW-1:0] lp [4][3];
    logic signed [WW-1:0] lane_res [3];
    logic        [2:0]    lane_done;
    logic                 done_all;

    // Whether neighbour k (0..3 around the segment) exists on an axis.
    function automatic logic need_pt(input logic [1:0] k, input logic [DW-1:0] seg,
                                     input logic [DW-1:0] d, input logic lin);
        logic r;
        case (k)
            2'd0:    r = !lin && (seg != '0);
            2'd3:    r = !lin && (({1'b0, seg} + 5'd2) <= {1'b0, d});
            default: r = 1'b1;
        endcase
        return r;
    endfunction

    // Segment and fraction of a clamped parameter on an axis of d divisions.
    function automatic logic [DW+TW-1:0] pick(input logic [TW-1:0] c,
                                              input logic [DW-1:0] d);
        logic [TW+DW-2:0] s;
        logic [DW+TW-1:0] r;
        s = c[TW-2:0] * d;
        if (c >= ONE_Q16) begin
            r = {d - DW'(1), ONE_Q16};
        end else begin
            r = {s[TW+DW-2:TW-1], 1'b0, s[TW-2:0]};
        end
        return r;
    endfunction

    assign du_e  = (du_reg == '0) ? DW'(1) : du_reg;
    assign dv_e  = (dv_reg == '0) ? DW'(1) : dv_reg;
    assign lin_u = (du_e == DW'(1));
    assign lin_v = (dv_e == DW'(1));
    assign {pu_seg, pu_t} = pick(s_param_u, du_e);
    assign {pv_seg, pv_t} = pick(s_param_v, dv_e);

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign mem_we  = accept && (s_action == ACT_LOAD);

    // Grid slot of column k of the current row; the sum wraps to the store.
    assign row_num  = {1'b0, v_seg_reg} + {3'd0, rk_reg} - 5'd1;
    assign addr_w   = row_num * ({1'b0, du_e} + 5'd1)
                    + {6'd0, u_seg_reg} + {8'd0, k_reg} - 10'd1;
    assign mem_addr = mem_we ? s_point_index : addr_w[AW-1:0];

    crle_grid_mem u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (s_point_index),
        .wr_data ({s_point_z, s_point_y, s_point_x}),
        .rd_addr (mem_addr),
        .rd_data (mem_rdata)
    );

    // Lanes take grid points during the row pass and row results at the end.
    always_comb begin
        lane_ctl.start  = (state_reg == S_USTART) || vstart_reg;
        lane_ctl.linear = vstart_reg ? lin_v : lin_u;
        lane_ctl.refl0  = vstart_reg ? !need_pt(2'd0, v_seg_reg, dv_e, lin_v)
                                     : !need_pt(2'd0, u_seg_reg, du_e, lin_u);
        lane_ctl.refl3  = vstart_reg ? !need_pt(2'd3, v_seg_reg, dv_e, lin_v)
                                     : !need_pt(2'd3, u_seg_reg, du_e, lin_u);
        lane_t = (state_reg == S_VRUN) ? v_t_reg : u_t_reg;
        for (int j = 0; j < 4; j++) begin
            for (int c = 0; c < 3; c++) begin
                lp[j][c] = vstart_reg ? row_reg[j][c] : WW'(pt_reg[j][c]);
            end
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_lane
        crle_cubic_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (lane_ctl),
            .t       (lane_t),
            .p0      (lp[0][c]),
            .p1      (lp[1][c]),
            .p2      (lp[2][c]),
            .p3      (lp[3][c]),
            .result  (lane_res[c]),
            .done    (lane_done[c])
        );
    end

    assign done_all = &lane_done;

    function automatic logic signed [CW-1:0] sat(input logic signed [WW-1:0] v);
        logic signed [CW-1:0] r;
        if (v > WW'(32'sh7FFF_FFFF)) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -(WW'(33'sh0_8000_0000))) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[CW-1:0];
        end
        return r;
    endfunction

    always_comb begin
        state_next   = state_reg;
        vstart_next  = 1'b0;
        u_seg_next   = u_seg_reg;
        v_seg_next   = v_seg_reg;
        u_t_next     = u_t_reg;
        v_t_next     = v_t_reg;
        rk_next      = rk_reg;
        k_next       = k_reg;
        rd_v_next    = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            S_IDLE: begin
                if (accept && (s_action == ACT_EVAL)) begin
                    u_seg_next = pu_seg;
                    u_t_next   = pu_t;
                    v_seg_next = pv_seg;
                    v_t_next   = pv_t;
                    rk_next    = 2'd0;
                    state_next = S_ROW;
                end
            end
            S_ROW: begin
                k_next = 2'd0;
                if (need_pt(rk_reg, v_seg_reg, dv_e, lin_v)) begin
                    state_next = S_RD;
                end else if (rk_reg == 2'd3) begin
                    vstart_next = 1'b1;
                    state_next  = S_VRUN;
                end else begin
                    rk_next = rk_reg + 2'd1;
                end
            end
            S_RD: begin
                rd_v_next = need_pt(k_reg, u_seg_reg, du_e, lin_u);
                k_next    = k_reg + 2'd1;
                if (k_reg == 2'd3) begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT: begin
                state_next = S_USTART;
            end
            S_USTART: begin
                state_next = S_URUN;
            end
            S_URUN: begin
                if (done_all) begin
                    if (rk_reg == 2'd3) begin
                        vstart_next = 1'b1;
                        state_next  = S_VRUN;
                    end else begin
                        rk_next    = rk_reg + 2'd1;
                        state_next = S_ROW;
                    end
                end
            end
            S_VRUN: begin
                if (done_all) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            vstart_reg  <= 1'b0;
            rd_v_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            du_reg      <= DW'(1);
            dv_reg      <= DW'(1);
        end else begin
            state_reg   <= state_next;
            vstart_reg  <= vstart_next;
            rd_v_reg    <= rd_v_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en && (cfg_index == REG_DIV_ACROSS)) begin
                du_reg <= cfg_wdata;
            end
            if (cfg_wr_en && (cfg_index == REG_DIV_DOWN)) begin
                dv_reg <= cfg_wdata;
            end
        end
        u_seg_reg <= u_seg_next;
        v_seg_reg <= v_seg_next;
        u_t_reg   <= u_t_next;
        v_t_reg   <= v_t_next;
        rk_reg    <= rk_next;
        k_reg     <= k_next;
        rd_k_reg  <= k_reg;
        if (rd_v_reg) begin
            pt_reg[rd_k_reg][0] <= mem_rdata[CW-1:0];
            pt_reg[rd_k_reg][1] <= mem_rdata[2*CW-1:CW];
            pt_reg[rd_k_reg][2] <= mem_rdata[3*CW-1:2*CW];
        end
        if ((state_reg == S_URUN) && done_all) begin
            for (int c = 0; c < 3; c++) begin
                row_reg[rk_reg][c] <= lane_res[c];
            end
        end
        if ((state_reg == S_VRUN) && done_all) begin
            for (int c = 0; c < 3; c++) begin
                res_reg[c] <= sat(lane_res[c]);
            end
        end
        if ((state_reg == S_FIN) && (!m_valid_reg || m_ready)) begin
            mx_reg <= res_reg[0];
            my_reg <= res_reg[1];
            mz_reg <= res_reg[2];
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_surface_x = mx_reg;
    assign m_surface_y = my_reg;
    assign m_surface_z = mz_reg;

endmodule

// ----- hw/rtl/crle_checker.sv -----
// Port-level checks for the lattice evaluator and their bind to the top.
// Depends on crle_pkg and catmull_rom_lattice_evaluator_unit.
module crle_checker
    import crle_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic signed [CW-1:0] m_surface_x,
    input logic signed [CW-1:0] m_surface_y,
    input logic signed [CW-1:0] m_surface_z
);

    // A stalled result keeps its valid and its payload.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_surface_x)
            && $stable(m_surface_y) && $stable(m_surface_z))
        else $error("stalled result changed");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // No item produces a result in the very next cycle.
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result appeared right after an accepted item");

endmodule

bind catmull_rom_lattice_evaluator_unit crle_checker u_crle_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_surface_x (m_surface_x),
    .m_surface_y (m_surface_y),
    .m_surface_z (m_surface_z)
);

// ----- tb/catmull_rom_lattice_evaluator_unit_tb.sv -----
// Self-checking testbench for the Catmull-Rom lattice evaluator: loads control point
// lattices, evaluates surface points and compares every result with a model or table value.
// Depends on crle_pkg and the RTL top level catmull_rom_lattice_evaluator_unit.
module catmull_rom_lattice_evaluator_unit_tb
    import crle_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 80;   // idle time after draining, longer than a full 4x4 evaluate

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [1:0]           cfg_index = REG_DIV_ACROSS;
    logic [DW-1:0]        cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_action = ACT_LOAD;
    logic [AW-1:0]        s_point_index = '0;
    logic signed [CW-1:0] s_point_x = '0;
    logic signed [CW-1:0] s_point_y = '0;
    logic signed [CW-1:0] s_point_z = '0;
    logic [TW-1:0]        s_param_u = '0;
    logic [TW-1:0]        s_param_v = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic signed [CW-1:0] m_surface_x;
    logic signed [CW-1:0] m_surface_y;
    logic signed [CW-1:0] m_surface_z;

    always #6 aclk = ~aclk;

    catmull_rom_lattice_evaluator_unit dut (.*);

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } point_t;

    typedef struct {
        logic                 action;
        logic [AW-1:0]        slot;
        point_t               pt;
        logic [TW-1:0]        u;
        logic [TW-1:0]        v;
        bit                   typed;
        point_t               want;
    } stim_row_t;

    // Shadow of the grid and of the division registers.
    longint       lattice [3][GRID_DEPTH];
    logic [DW-1:0] across_reg = 4'd1;
    logic [DW-1:0] down_reg = 4'd1;

    point_t pending_points[$];
    int     errors = 0;
    int     loads_sent = 0;
    int     evals_sent = 0;
    int     points_checked = 0;
    int     settings_used = 0;
    int     burst_left = 0;

    // Product h*t/65536 rounded to nearest, ties upward.
    function automatic longint mul_q16(longint h, longint t);
        longint lo, hi;
        lo = h & 64'hFFFF;
        hi = (h - lo) >>> 16;
        return hi * t + ((lo * t + 32768) >>> 16);
    endfunction

    function automatic longint spline(longint p0, longint p1, longint p2, longint p3,
                                      longint t);
        longint acc;
        acc = -p0 + 3 * p1 - 3 * p2 + p3;
        acc = (2 * p0 - 5 * p1 + 4 * p2 - p3) + mul_q16(acc, t);
        acc = (p2 - p0) + mul_q16(acc, t);
        acc = 2 * p1 + mul_q16(acc, t);
        return (acc + 1) >>> 1;          // halve, ties upward
    endfunction

    function automatic int eff_divs(logic [DW-1:0] d);
        return (d == 0) ? 1 : int'(d);
    endfunction

    // Segment and fraction of a clamped parameter on an axis of d divisions.
    function automatic void locate(int d, longint c, output int seg, output longint t);
        if (c >= 65536) begin
            seg = d - 1;
            t = 65536;
        end else begin
            seg = int'((c * d) >> 16);
            t = (c * d) & 64'hFFFF;
        end
    endfunction

    function automatic longint grid_at(int comp, int slot);
        return lattice[comp][slot % GRID_DEPTH];
    endfunction

    function automatic longint row_value(int comp, int row, int du, longint cu);
        int     seg, base;
        longint t, p0, p1, p2, p3;
        base = row * (du + 1);
        locate(du, cu, seg, t);
        p1 = grid_at(comp, base + seg);
        p2 = grid_at(comp, base + seg + 1);
        if (du == 1)
            return p1 + mul_q16(p2 - p1, t);
        p0 = (seg == 0) ? 2 * p1 - p2 : grid_at(comp, base + seg - 1);
        p3 = (seg + 2 > du) ? 2 * p2 - p1 : grid_at(comp, base + seg + 2);
        return spline(p0, p1, p2, p3, t);
    endfunction

    function automatic logic signed [CW-1:0] surface_coord(int comp, longint cu, longint cv);
        int     du, dv, seg;
        longint t, p0, p1, p2, p3, r;
        du = eff_divs(across_reg);
        dv = eff_divs(down_reg);
        locate(dv, cv, seg, t);
        p1 = row_value(comp, seg, du, cu);
        p2 = row_value(comp, seg + 1, du, cu);
        if (dv == 1) begin
            r = p1 + mul_q16(p2 - p1, t);
        end else begin
            p0 = (seg == 0) ? 2 * p1 - p2 : row_value(comp, seg - 1, du, cu);
            p3 = (seg + 2 > dv) ? 2 * p2 - p1 : row_value(comp, seg + 2, du, cu);
            r = spline(p0, p1, p2, p3, t);
        end
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[CW-1:0];
    endfunction

    function automatic point_t evaluate_point(logic [TW-1:0] u, logic [TW-1:0] v);
        point_t p;
        longint cu, cv;
        cu = (u > ONE_Q16) ? 65536 : longint'(u);
        cv = (v > ONE_Q16) ? 65536 : longint'(v);
        p.x = surface_coord(0, cu, cv);
        p.y = surface_coord(1, cu, cv);
        p.z = surface_coord(2, cu, cv);
        return p;
    endfunction

    // Coordinates mix full-range values, small ones and the two extremes, so that
    // both ordinary interpolation and saturation occur.
    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFFFFFF;
            1:       return 32'sh80000000;
            2, 3, 4: return $urandom;
            default: return $signed($urandom_range(0, 32'h1FFFFF)) - 32'sh100000;
        endcase
    endfunction

    function automatic logic [TW-1:0] rand_param();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ONE_Q16;
            2:       return TW'($urandom_range(65537, 131071));   // clamps to one
            default: return TW'($urandom_range(0, 65535));
        endcase
    endfunction

    // Sender: bursts of random length with random gaps in between.
    task automatic send_item(logic action, logic [AW-1:0] slot, point_t pt,
                             logic [TW-1:0] u, logic [TW-1:0] v,
                             bit typed, point_t want);
        if (burst_left == 0) begin
            s_valid = 1'b0;
            if ($urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 12)) @(negedge aclk);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_valid = 1'b1;
        s_action = action;
        s_point_index = slot;
        s_point_x = pt.x;
        s_point_y = pt.y;
        s_point_z = pt.z;
        s_param_u = u;
        s_param_v = v;
        do @(posedge aclk); while (!s_ready);
        if (action == ACT_LOAD) begin
            lattice[0][slot] = pt.x;
            lattice[1][slot] = pt.y;
            lattice[2][slot] = pt.z;
            loads_sent++;
        end else begin
            pending_points.push_back(typed ? want : evaluate_point(u, v));
            evals_sent++;
        end
        @(negedge aclk);
        if (burst_left == 0) s_valid = 1'b0;
    endtask

    task automatic load_point(int slot, point_t pt);
        send_item(ACT_LOAD, slot[AW-1:0], pt, rand_param(), rand_param(), 1'b0, pt);
    endtask

    // Registers change only when the block is idle: drain, then let it settle.
    task automatic set_divisions(logic [DW-1:0] across, logic [DW-1:0] down);
        s_valid = 1'b0;
        burst_left = 0;
        while (pending_points.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = REG_DIV_ACROSS;
        cfg_wdata = across;
        @(negedge aclk);
        cfg_index = REG_DIV_DOWN;
        cfg_wdata = down;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        across_reg = across;
        down_reg = down;
        settings_used++;
    endtask

    // One random phase: load the whole lattice for the current sizes, then mix
    // evaluates with reloads of lattice slots and loads anywhere in the store.
    task automatic random_phase(int count);
        int     cells, k;
        point_t pt;
        cells = (eff_divs(across_reg) + 1) * (eff_divs(down_reg) + 1);
        for (k = 0; k < cells; k++) begin
            pt.x = rand_coord();
            pt.y = rand_coord();
            pt.z = rand_coord();
            load_point(k, pt);
        end
        for (k = 0; k < count; k++) begin
            pt.x = rand_coord();
            pt.y = rand_coord();
            pt.z = rand_coord();
            case ($urandom_range(0, 9))
                0:       load_point($urandom_range(0, cells - 1), pt);
                1:       load_point($urandom_range(0, GRID_DEPTH - 1), pt);
                default: send_item(ACT_EVAL, AW'($urandom), pt, rand_param(),
                                   rand_param(), 1'b0, pt);
            endcase
        end
    endtask

    // Receiver: changes its stall pattern at random intervals, from always ready to
    // mostly stalled.
    int stall_mode = 0;
    int mode_cycles = 0;
    always @(negedge aclk) begin
        if (mode_cycles == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_cycles <= $urandom_range(50, 400);
        end else begin
            mode_cycles <= mode_cycles - 1;
        end
        case (stall_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= ($urandom_range(0, 1) == 1);
            2:       m_ready <= ($urandom_range(0, 4) == 0);
            default: m_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Result checker: every accepted result against the oldest expectation.
    always @(posedge aclk) begin
        point_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_points.size() == 0) begin
                $display("%0t: unexpected result x=%h y=%h z=%h", $time,
                         m_surface_x, m_surface_y, m_surface_z);
                errors++;
            end else begin
                want = pending_points.pop_front();
                points_checked++;
                if (m_surface_x !== want.x) begin
                    $display("%0t: surface_x expected %h, got %h", $time, want.x, m_surface_x);
                    errors++;
                end
                if (m_surface_y !== want.y) begin
                    $display("%0t: surface_y expected %h, got %h", $time, want.y, m_surface_y);
                    errors++;
                end
                if (m_surface_z !== want.z) begin
                    $display("%0t: surface_z expected %h, got %h", $time, want.z, m_surface_z);
                    errors++;
                end
            end
        end
    end

    // Directed table, run with the reset sizes (2 x 2 lattice, slot = row*2 + col).
    // At the corners of the unit square the surface equals the corner point.
    localparam point_t P0 = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh00000000};
    localparam point_t P1 = '{32'sh00000000, 32'sh00010000, 32'shFFFFFFFF};
    localparam point_t P2 = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh12345678};
    localparam point_t P3 = '{32'sh00000001, 32'shFFFFFFFF, 32'sh00030000};
    localparam point_t PX = '{32'sh5A5A5A5A, 32'shA5A5A5A5, 32'sh0F0F0F0F};

    stim_row_t directed [] = '{
        '{ACT_LOAD, 8'd0,   P0, 17'd0,      17'd0,      1'b0, P0},
        '{ACT_LOAD, 8'd1,   P1, 17'd0,      17'd0,      1'b0, P1},
        '{ACT_LOAD, 8'd2,   P2, 17'd0,      17'd0,      1'b0, P2},
        '{ACT_LOAD, 8'd3,   P3, 17'd0,      17'd0,      1'b0, P3},
        '{ACT_EVAL, 8'd0,   PX, 17'd0,      17'd0,      1'b1, P0},
        '{ACT_EVAL, 8'd0,   PX, 17'd65536,  17'd0,      1'b1, P1},
        '{ACT_EVAL, 8'd0,   PX, 17'd0,      17'd65536,  1'b1, P2},
        '{ACT_EVAL, 8'd0,   PX, 17'd65536,  17'd65536,  1'b1, P3},
        '{ACT_EVAL, 8'd0,   PX, 17'h1FFFF,  17'h1FFFF,  1'b1, P3},
        '{ACT_EVAL, 8'hFF,  PX, 17'h1FFFF,  17'd0,      1'b1, P1},
        '{ACT_EVAL, 8'd0,   PX, 17'd32768,  17'd32768,  1'b0, PX},
        '{ACT_EVAL, 8'd0,   PX, 17'd1,      17'd65535,  1'b0, PX},
        '{ACT_EVAL, 8'd0,   PX, 17'd65535,  17'd1,      1'b0, PX},
        '{ACT_LOAD, 8'hFF,  PX, 17'h1FFFF,  17'h1FFFF,  1'b0, PX},
        '{ACT_EVAL, 8'd0,   PX, 17'd0,      17'd0,      1'b1, P0},
        '{ACT_LOAD, 8'd3,   PX, 17'd0,      17'd0,      1'b0, PX},
        '{ACT_EVAL, 8'd0,   PX, 17'd65536,  17'd65536,  1'b1, PX},
        '{ACT_EVAL, 8'd0,   PX, 17'd40000,  17'd20000,  1'b0, PX}
    };

    // Division settings for the random phases: extremes, the zero case, uneven
    // shapes and a few middle sizes.
    logic [DW-1:0] phase_divs [][2] = '{
        '{4'd15, 4'd15}, '{4'd0, 4'd0}, '{4'd0, 4'd15}, '{4'd15, 4'd1},
        '{4'd2, 4'd3},   '{4'd3, 4'd2}, '{4'd1, 4'd4},  '{4'd5, 4'd1},
        '{4'd7, 4'd7},   '{4'd1, 4'd1}, '{4'd2, 4'd2},  '{4'd4, 4'd6}
    };

    initial begin
        int i;
        for (i = 0; i < GRID_DEPTH; i++) begin
            lattice[0][i] = 0;
            lattice[1][i] = 0;
            lattice[2][i] = 0;
        end
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (directed[r])
            send_item(directed[r].action, directed[r].slot, directed[r].pt,
                      directed[r].u, directed[r].v, directed[r].typed, directed[r].want);

        foreach (phase_divs[p]) begin
            set_divisions(phase_divs[p][0], phase_divs[p][1]);
            random_phase(110);
        end
        set_divisions(DW'($urandom_range(0, 15)), DW'($urandom_range(0, 15)));
        random_phase(110);

        s_valid = 1'b0;
        while (pending_points.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("Covered %0d loads and %0d evaluates over %0d division settings;",
                 loads_sent, evals_sent, settings_used);
        $display("%0d surface points compared, %0d mismatches.", points_checked, errors);
        if (errors == 0 && pending_points.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #40ms;
        $display("Timed out with %0d results outstanding.", pending_points.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
